[rtl/mmt_pkg.sv]
// ----------------------------------------------------------------------------
// mmt_pkg
// Shared types, codes and helpers for the multi-mode timer table.
// ----------------------------------------------------------------------------
package mmt_pkg;

    localparam int TIMER_SLOTS_DEF = 16;
    localparam int TIME_W          = 48;
    localparam int IVAL_W          = 32;
    localparam int CNT_W           = 16;

    localparam logic [2:0] OP_START_PERIODIC = 3'd0;
    localparam logic [2:0] OP_START_ONCE     = 3'd1;
    localparam logic [2:0] OP_START_COUNTED  = 3'd2;
    localparam logic [2:0] OP_STOP           = 3'd3;
    localparam logic [2:0] OP_TICK           = 3'd4;

    localparam logic [1:0] MODE_PERIODIC = 2'd0;
    localparam logic [1:0] MODE_ONCE     = 2'd1;
    localparam logic [1:0] MODE_COUNTED  = 2'd2;

    localparam logic [1:0] KIND_STATUS  = 2'd0;
    localparam logic [1:0] KIND_FIRED   = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0] deadline;
        logic [IVAL_W-1:0] period;
        logic [1:0]        mode;
        logic [CNT_W-1:0]  limit_count;
        logic [CNT_W-1:0]  fire_count;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_DECIDE,
        ST_FIRE_RD,
        ST_FIRE_WR,
        ST_SUM
    } state_t;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] t,
                                                  input logic [IVAL_W-1:0] d);
        logic [TIME_W:0] s;
        s = {1'b0, t} + {{(TIME_W-IVAL_W+1){1'b0}}, d};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

endpackage

[rtl/mmt_mem.sv]
// ----------------------------------------------------------------------------
// mmt_mem
// Slot table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mmt_mem #(
    parameter int DEPTH = mmt_pkg::TIMER_SLOTS_DEF,
    parameter int AW    = 4
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  mmt_pkg::entry_t wdata,
    input  logic [AW-1:0]   raddr,
    output mmt_pkg::entry_t rdata
);
    import mmt_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/mmt_ctrl.sv]
// ----------------------------------------------------------------------------
// mmt_ctrl
// Command sequencer: start/stop handling, tick scan and ordered fire loop.
// ----------------------------------------------------------------------------
module mmt_ctrl #(
    parameter int TIMER_SLOTS = mmt_pkg::TIMER_SLOTS_DEF,
    parameter int AW          = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [2:0]      operation,
    input  logic [3:0]      slot_id,
    input  logic [31:0]     interval_ms,
    input  logic [15:0]     repeat_count,
    input  logic [47:0]     now_ms,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [1:0]      kind,
    output logic [3:0]      fired_slot,
    output logic            status,
    output logic [4:0]      fired_total,
    output logic            last,
    output logic            mem_we,
    output logic [AW-1:0]   mem_waddr,
    output mmt_pkg::entry_t mem_wdata,
    output logic [AW-1:0]   mem_raddr,
    input  mmt_pkg::entry_t mem_rdata
);
    import mmt_pkg::*;

    state_t                 state_reg, state_next;
    logic [TIMER_SLOTS-1:0] armed_reg;
    logic [TIMER_SLOTS-1:0] pending_reg;
    logic [AW-1:0]          rd_cnt_reg;
    logic                   cmp_v_reg;
    logic [AW-1:0]          cmp_idx_reg;
    logic                   found_reg;
    logic [AW-1:0]          best_reg;
    logic [TIME_W-1:0]      best_dl_reg;
    logic [TIME_W-1:0]      now_reg;
    logic [4:0]             total_reg;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [1:0]             kind_reg;
    logic [3:0]             slot_reg;
    logic                   status_reg;
    logic [4:0]             ftot_reg;
    logic                   last_reg;

    logic [6:0]             sid_ext;
    logic                   in_range;
    logic [AW-1:0]          idx;
    logic                   accept;
    logic                   out_free;
    logic                   cand;
    logic [CNT_W-1:0]       cnt1;
    logic                   dead;
    logic [6:0]             best_ext;
    entry_t                 start_e;
    entry_t                 fire_e;

    assign sid_ext  = 7'(slot_id);
    assign in_range = sid_ext < 7'(TIMER_SLOTS);
    assign idx      = sid_ext[AW-1:0];
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE) || !out_free;
    assign accept   = in_valid && !in_stall;
    assign best_ext = 7'(best_reg);

    assign out_valid_next = ((state_reg == ST_IDLE) && accept && (operation != OP_TICK)) ||
                            (((state_reg == ST_FIRE_WR) || (state_reg == ST_SUM)) && out_free) ||
                            (out_valid_reg && out_stall);

    assign cand = cmp_v_reg && pending_reg[cmp_idx_reg] && (mem_rdata.deadline < now_reg);
    assign cnt1 = mem_rdata.fire_count + 1'b1;
    assign dead = (mem_rdata.mode == MODE_ONCE) ||
                  ((mem_rdata.mode == MODE_COUNTED) && (mem_rdata.limit_count <= cnt1));

    always_comb
    begin
        start_e.deadline    = sat_add(now_ms, interval_ms);
        start_e.period      = interval_ms;
        start_e.mode        = operation[1:0];
        start_e.limit_count = (operation == OP_START_COUNTED) ? repeat_count : '0;
        start_e.fire_count  = '0;
        fire_e              = mem_rdata;
        fire_e.fire_count   = cnt1;
        if (!dead)
        begin
            fire_e.deadline = sat_add(now_reg, mem_rdata.period);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mem_we     = 1'b0;
        mem_waddr  = idx;
        mem_wdata  = start_e;
        mem_raddr  = rd_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && operation <= OP_START_COUNTED && in_range && !armed_reg[idx])
                begin
                    mem_we = 1'b1;
                end
                if (accept && operation == OP_TICK)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (rd_cnt_reg == AW'(TIMER_SLOTS - 1))
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                state_next = found_reg ? ST_FIRE_RD : ST_SUM;
            end
            ST_FIRE_RD:
            begin
                mem_raddr  = best_reg;
                state_next = ST_FIRE_WR;
            end
            ST_FIRE_WR:
            begin
                // keep the selected entry on the read port while the output stalls
                mem_raddr = best_reg;
                mem_waddr = best_reg;
                mem_wdata = fire_e;
                if (out_free)
                begin
                    mem_we     = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SUM:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            armed_reg     <= '0;
            pending_reg   <= '0;
            rd_cnt_reg    <= '0;
            cmp_v_reg     <= 1'b0;
            found_reg     <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_v_reg     <= (state_reg == ST_SCAN);
            cmp_idx_reg   <= rd_cnt_reg;
            out_valid_reg <= out_valid_next;
            if (cand && (!found_reg || mem_rdata.deadline < best_dl_reg))
            begin
                found_reg   <= 1'b1;
                best_reg    <= cmp_idx_reg;
                best_dl_reg <= mem_rdata.deadline;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (operation == OP_TICK)
                        begin
                            now_reg     <= now_ms;
                            pending_reg <= armed_reg;
                            rd_cnt_reg  <= '0;
                            found_reg   <= 1'b0;
                            total_reg   <= '0;
                        end
                        else
                        begin
                            kind_reg      <= KIND_STATUS;
                            slot_reg      <= slot_id;
                            status_reg    <= (operation <= OP_START_COUNTED) && in_range &&
                                             armed_reg[idx];
                            ftot_reg      <= '0;
                            last_reg      <= 1'b1;
                            if (in_range && operation <= OP_START_COUNTED)
                            begin
                                armed_reg[idx] <= 1'b1;
                            end
                            if (in_range && operation == OP_STOP)
                            begin
                                armed_reg[idx] <= 1'b0;
                            end
                        end
                    end
                end
                ST_SCAN:
                begin
                    rd_cnt_reg <= rd_cnt_reg + 1'b1;
                end
                ST_FIRE_WR:
                begin
                    if (out_free)
                    begin
                        pending_reg[best_reg] <= 1'b0;
                        if (dead)
                        begin
                            armed_reg[best_reg] <= 1'b0;
                        end
                        total_reg     <= total_reg + 1'b1;
                        found_reg     <= 1'b0;
                        rd_cnt_reg    <= '0;
                        kind_reg      <= KIND_FIRED;
                        slot_reg      <= best_ext[3:0];
                        status_reg    <= 1'b0;
                        ftot_reg      <= '0;
                        last_reg      <= 1'b0;
                    end
                end
                ST_SUM:
                begin
                    if (out_free)
                    begin
                        kind_reg      <= KIND_SUMMARY;
                        slot_reg      <= '0;
                        status_reg    <= 1'b0;
                        ftot_reg      <= total_reg;
                        last_reg      <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign fired_slot  = slot_reg;
    assign status      = status_reg;
    assign fired_total = ftot_reg;
    assign last        = last_reg;

endmodule

[rtl/multi_mode_timer_table.sv]
// Start, stop and other commands: the status word follows in the cycle after acceptance.
// Tick: one table sweep per fired timer plus one closing sweep, set by the single read port.
// Next word accepted once a tick's summary has been loaded.
// Reset (rst_n, async) clears all armed flags and the sequencer; slot data is not cleared.
// ----------------------------------------------------------------------------
// multi_mode_timer_table
// Table of periodic, one-shot and counted timers held in a slot memory.
// ----------------------------------------------------------------------------
module multi_mode_timer_table #(
    parameter int TIMER_SLOTS = mmt_pkg::TIMER_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  operation,
    input  logic [3:0]  slot_id,
    input  logic [31:0] interval_ms,
    input  logic [15:0] repeat_count,
    input  logic [47:0] now_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [3:0]  fired_slot,
    output logic        status,
    output logic [4:0]  fired_total,
    output logic        last
);
    import mmt_pkg::*;

    localparam int AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    entry_t        mem_wdata;
    entry_t        mem_rdata;

    mmt_ctrl #(
        .TIMER_SLOTS (TIMER_SLOTS),
        .AW          (AW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .slot_id      (slot_id),
        .interval_ms  (interval_ms),
        .repeat_count (repeat_count),
        .now_ms       (now_ms),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .fired_slot   (fired_slot),
        .status       (status),
        .fired_total  (fired_total),
        .last         (last),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata)
    );

    mmt_mem #(
        .DEPTH (TIMER_SLOTS),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

[rtl/mmt_checker.sv]
// ----------------------------------------------------------------------------
// mmt_checker
// Port-level checks for the timer table, bound to the top level.
// ----------------------------------------------------------------------------
module mmt_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [2:0] operation,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] kind,
    input logic [3:0] fired_slot,
    input logic       last
);
    import mmt_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(fired_slot))
        else $error("stalled output word changed");

    a_cmd_status: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && operation != OP_TICK |=>
            out_valid && last && kind == KIND_STATUS)
        else $error("command did not give a closing status word");

    a_fired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_FIRED |-> !last)
        else $error("fired word marked last");

    a_summary: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_SUMMARY |-> last && fired_slot == 4'd0)
        else $error("malformed summary word");

endmodule

bind multi_mode_timer_table mmt_checker u_mmt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .fired_slot (fired_slot),
    .last       (last)
);
